FILE: rtl/core/sha512_pkg.sv
// SHA-512 constants, round constant table and shared types.
`timescale 1ns / 1ps
package sha512_pkg;
  typedef logic [63:0] word_t;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned PadLimit   = 112;
  localparam int unsigned Rounds     = 80;

  // Operations that the sequencer issues to the compression round unit.
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_START,
    OP_ROUND,
    OP_FOLD
  } cmp_op_t;

  // Request to the compression unit: operation and round index.
  typedef struct packed {
    cmp_op_t    op;
    logic [6:0] round;
  } cmp_ctl_t;

  function automatic word_t initial_hash(input logic [2:0] idx);
    word_t r;
    r = '0;
    unique case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      3'd7: r = 64'h5be0cd19137e2179;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t round_const(input logic [6:0] t);
    word_t r;
    r = '0;
    unique case (t)
      7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/core/sha512_round.sv
// Shared SHA-512 round unit: working variables, rolling schedule and chaining hash.
`timescale 1ns / 1ps
module sha512_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha512_pkg::cmp_ctl_t  ctl,
  input  logic                  reinit,     // restore the initial hash values
  input  sha512_pkg::word_t     blk [16],   // block words loaded at OP_START
  input  logic [2:0]            rd_idx,
  output sha512_pkg::word_t     rd_word
);
  import sha512_pkg::*;

  word_t h_r [8];
  word_t v_r [8];
  word_t w_r [16];   // w_r[0] is the schedule word of the current round

  word_t s0, s1, w_new, t1, t2, big0, big1, ch, maj;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  always_comb begin
    s0    = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1    = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    big1  = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + ch + round_const(ctl.round) + w_r[0];
    big0  = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
  end

  assign rd_word = h_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= initial_hash(3'(i));
    end else if (reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= initial_hash(3'(i));
    end else if (ctl.op == OP_FOLD) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_START: begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        for (int i = 0; i < 16; i++) w_r[i] <= blk[i];
      end
      OP_ROUND: begin
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
      end
      OP_IDLE, OP_FOLD: ;
      default: ;
    endcase
  end
endmodule

FILE: rtl/core/sha512_stream_hasher.sv
// SHA-512 stream hasher top level: byte packer, padding sequencer, digest output.
//
// Input beats on in_*: tdata = message_word, tuser = byte_count (4 bits),
// tlast = last_item. Each beat appends up to eight bytes, first byte in
// bits 63..56. A beat is accepted in the idle state; the packer then moves
// one byte a cycle, except while a filled block is compressed, and then
// closes the beat. Each filled 128-byte block is then compressed in the
// shared round unit (load, 80 rounds, fold). in_tready is low while bytes
// are packed, a block is padded or compressed or a digest is being sent.
// On a last beat the block is padded (twice when 112 or more bytes are
// pending) and eight beats leave on out_*: tdata = digest_word,
// tuser = word_index (3 bits), tlast = last_word. A stalled receiver holds
// the current word; nothing else proceeds until all eight are taken.
// Afterwards the block restarts at the initial hash values. Reset (rst_n
// low, synchronous) restores the initial hash and clears counts; the block
// buffer holds no reset value.
`timescale 1ns / 1ps
module sha512_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // message_word
  input  logic [3:0]  in_tuser,   // byte_count
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PACK, S_PAD, S_START, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t     state_r;
  word_t      blk_r [16];
  logic [6:0] pos_r;
  logic [60:0] msg_r;
  word_t      word_r;
  logic [3:0] cnt_r;
  logic       last_r;
  logic       padded_r;     // 0x80 and zero fill already done for this block
  logic       final_r;      // block being compressed carries the length
  logic [6:0] round_r;
  logic [2:0] oidx_r;
  cmp_ctl_t   ctl;
  logic       reinit;
  logic       len_fit;      // length field goes into the block being padded
  word_t      hword;

  sha512_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .reinit(reinit),
    .blk(blk_r), .rd_idx(oidx_r), .rd_word(hword)
  );

  always_comb begin
    ctl.round = round_r;
    unique case (state_r)
      S_START: ctl.op = OP_START;
      S_ROUND: ctl.op = OP_ROUND;
      S_FOLD:  ctl.op = OP_FOLD;
      default: ctl.op = OP_IDLE;
    endcase
  end

  assign reinit     = (state_r == S_OUT) && out_tready && (oidx_r == 3'd7);
  assign len_fit    = padded_r || (pos_r < 7'(PadLimit));
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = hword;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  // Byte lane write helper: put byte b into the given lane of word w, lane 0 in bits 63..56.
  function automatic word_t put_byte(input word_t w, input logic [2:0] lane,
                                     input logic [7:0] b);
    word_t r;
    r = w;
    r[8*(7-lane) +: 8] = b;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      msg_r    <= '0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      padded_r <= 1'b0;
      final_r  <= 1'b0;
      round_r  <= '0;
      oidx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            word_r <= in_tdata;
            cnt_r  <= (in_tuser > 4'd8) ? 4'd8 : in_tuser;
            last_r <= in_tlast;
            msg_r  <= msg_r + 61'((in_tuser > 4'd8) ? 4'd8 : in_tuser);
            state_r <= S_PACK;
          end
        end
        S_PACK: begin
          if (cnt_r != 4'd0) begin
            blk_r[pos_r[6:3]] <= put_byte(blk_r[pos_r[6:3]], pos_r[2:0], word_r[63:56]);
            word_r <= word_r << 8;
            cnt_r  <= cnt_r - 4'd1;
            pos_r  <= pos_r + 7'd1;
            if (pos_r == 7'd127) begin
              final_r <= 1'b0;
              state_r <= S_START;
            end
          end else if (last_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          // zero the tail after pos and place the marker; length if room
          for (int i = 0; i < 16; i++) begin
            if (!(len_fit && i >= 14)) begin
              for (int j = 0; j < 8; j++) begin
                if (7'(i*8+j) > pos_r || padded_r) blk_r[i][8*(7-j) +: 8] <= 8'h00;
                else if (7'(i*8+j) == pos_r)     blk_r[i][8*(7-j) +: 8] <= 8'h80;
              end
            end
          end
          if (len_fit) begin
            blk_r[14] <= '0;
            blk_r[15] <= {msg_r, 3'b000};
            final_r   <= 1'b1;
          end else begin
            final_r <= 1'b0;
          end
          padded_r <= 1'b1;
          state_r  <= S_START;
        end
        S_START: begin
          round_r <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          round_r <= round_r + 7'd1;
          if (round_r == 7'(Rounds - 1)) state_r <= S_FOLD;
        end
        S_FOLD: begin
          pos_r <= '0;
          if (final_r) begin
            oidx_r  <= '0;
            state_r <= S_OUT;
          end else if (padded_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_PACK;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              msg_r    <= '0;
              padded_r <= 1'b0;
              final_r  <= 1'b0;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/sha512_checker.sv
// Port-level assertions for the SHA-512 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha512_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("digest beat changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'd7)))
    else $error("last flag does not match word index");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser == $past(out_tuser) + 3'd1)
    else $error("digest words out of order");
endmodule

bind sha512_stream_hasher sha512_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
